@@ rtl/wsp_pkg.sv @@
// Shared constants and codes for the world-to-screen projection block.
`timescale 1ns / 1ps

package wsp_pkg;

    // Default number of fraction bits in every fixed-point value.
    localparam int FRAC_BITS_DEF = 16;

    // Magnitude cap of the normalized coordinate, as a power of two.
    localparam int NDC_CAP = 46;

    // Quotient bits resolved by one divider stage.
    localparam int DIV_STEP_BITS = 2;

    // Number of coefficient slots: three rows of four.
    localparam int NCOEF = 12;

    // Width of the screen size registers and their reset values.
    localparam int CFG_W = 14;
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 14'd1920;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 14'd1080;

    // Input item commands.
    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_PROJECT = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

@@ rtl/world_to_screen_projection_top.sv @@
// Pipelined world-to-screen perspective projection with coefficient store.
// Stages in order: products, row sums, floor and offset, divider setup, the restoring
// divider stages, scale, and the output register that presents the result.
// Throughput: one item per cycle while the output is not stalled; the two restoring
// dividers resolve two bits per stage. A load item produces no result.
// Reset (aresetn low at a clock edge) clears the coefficients, empties the pipeline
// and sets the screen size to 1920 x 1080.
`timescale 1ns / 1ps

module world_to_screen_projection_top
    import wsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_addr,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [3:0]              s_coef_index,
    input  logic signed [31:0]      s_coef_value,
    input  logic signed [31:0]      s_world_x,
    input  logic signed [31:0]      s_world_y,
    input  logic signed [31:0]      s_world_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_visible,
    output logic signed [31:0]      m_screen_x,
    output logic signed [31:0]      m_screen_y
);

    localparam int PW       = 64;
    localparam int SW       = 66;
    localparam int DW       = 67 - FRAC_BITS;
    localparam int RW       = DW;
    localparam int SH       = NDC_CAP - FRAC_BITS;
    localparam int OW       = DW + SH;
    localparam int NW       = NDC_CAP + 2;
    localparam int PRW      = NW + CFG_W + 1;
    localparam int NDS      = NDC_CAP / DIV_STEP_BITS;
    localparam int NS       = NDS + 6;
    localparam int ST_DIV0  = 3;
    localparam int ST_SCALE = NDS + 4;
    localparam int ST_OUT   = NDS + 5;
    localparam int THR      = ((2 ** FRAC_BITS) + 500) / 1000;
    localparam logic signed [DW-1:0] THR_V = DW'(THR);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // Pipeline control.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    logic          accept;

    // Configuration and coefficient state.
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic signed [31:0] coef_reg [NCOEF];

    // Datapath registers.
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [31:0]   ofs0_reg [3];
    logic signed [SW-1:0] sum_reg  [3];
    logic signed [31:0]   ofs1_reg [3];
    logic signed [DW-1:0] dot_reg  [3];

    logic [RW-1:0]      rem_reg [NDS+1][2];
    logic [NDC_CAP-1:0] nlo_reg [NDS+1][2];
    logic [NDC_CAP-1:0] quo_reg [NDS+1][2];
    logic               neg_reg [NDS+1][2];
    logic               ovf_reg [NDS+1][2];
    logic [DW-2:0]      den_reg [NDS+1];
    logic               vis_reg [NDS+1];

    logic signed [PRW-1:0] sprod_reg [2];
    logic                  svis_reg;

    logic                  vis_out_reg;
    logic signed [31:0]    sx_out_reg;
    logic signed [31:0]    sy_out_reg;

    // Enable chain: a stage loads when it is empty or the next stage loads.
    always_comb begin
        en[NS-1] = ~vld_reg[NS-1] | m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = ~vld_reg[k] | en[k+1];
        end
    end

    assign s_ready = en[0];
    assign accept  = s_valid & s_ready;

    // Valid bits travel with the data; load items leave no trace in the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid & (cmd_t'(s_command) == CMD_PROJECT);
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Screen size registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Coefficient store; a load to a slot beyond the last is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCOEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (accept && cmd_t'(s_command) == CMD_LOAD &&
                     s_coef_index < 4'(NCOEF)) begin
            coef_reg[s_coef_index] <= s_coef_value;
        end
    end

    // Stage 0: the nine coefficient-by-coordinate products.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[r][0] <= PW'(coef_reg[r*4+0]) * PW'(s_world_x);
                prod_reg[r][1] <= PW'(coef_reg[r*4+1]) * PW'(s_world_y);
                prod_reg[r][2] <= PW'(coef_reg[r*4+2]) * PW'(s_world_z);
                ofs0_reg[r]    <= coef_reg[r*4+3];
            end
        end
    end

    // Stage 1: exact sum of the three products of each row.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int r = 0; r < 3; r++) begin
                sum_reg[r]  <= SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) +
                               SW'(prod_reg[r][2]);
                ofs1_reg[r] <= ofs0_reg[r];
            end
        end
    end

    // Stage 2: floor to the fixed-point grid and add the constant term.
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int r = 0; r < 3; r++) begin
                dot_reg[r] <= DW'(sum_reg[r] >>> FRAC_BITS) + DW'(ofs1_reg[r]);
            end
        end
    end

    // Stage 3: visibility test, magnitudes, overflow check and divider setup.
    logic [DW-1:0]           abs_c [2];
    logic [DW+FRAC_BITS-1:0] nsh_c [2];
    logic [DW-2:0]           den_c;

    always_comb begin
        den_c = dot_reg[2][DW-2:0];
        for (int l = 0; l < 2; l++) begin
            abs_c[l] = dot_reg[l][DW-1] ? DW'(-dot_reg[l]) : DW'(dot_reg[l]);
            nsh_c[l] = {abs_c[l], {FRAC_BITS{1'b0}}};
        end
    end

    // The quotient saturates when the integer part reaches 2^SH.
    always_ff @(posedge aclk) begin
        if (en[ST_DIV0]) begin
            den_reg[0] <= den_c;
            vis_reg[0] <= dot_reg[2] > THR_V;
            for (int l = 0; l < 2; l++) begin
                rem_reg[0][l] <= RW'(abs_c[l] >> SH);
                nlo_reg[0][l] <= nsh_c[l][NDC_CAP-1:0];
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= dot_reg[l][DW-1];
                ovf_reg[0][l] <= OW'(abs_c[l]) >=
                                 OW'({1'b0, den_c, {SH{1'b0}}});
            end
        end
    end

    // Divider stages: restoring division, DIV_STEP_BITS quotient bits per stage.
    for (genvar j = 1; j <= NDS; j++) begin : g_div
        logic [RW-1:0]      rem_c [2];
        logic [NDC_CAP-1:0] nlo_c [2];
        logic [NDC_CAP-1:0] quo_c [2];

        always_comb begin
            logic [RW-1:0] tr;
            tr = '0;
            for (int l = 0; l < 2; l++) begin
                rem_c[l] = rem_reg[j-1][l];
                nlo_c[l] = nlo_reg[j-1][l];
                quo_c[l] = quo_reg[j-1][l];
                for (int b = 0; b < DIV_STEP_BITS; b++) begin
                    tr       = {rem_c[l][RW-2:0], nlo_c[l][NDC_CAP-1]};
                    nlo_c[l] = {nlo_c[l][NDC_CAP-2:0], 1'b0};
                    if (tr >= RW'(den_reg[j-1])) begin
                        rem_c[l] = tr - RW'(den_reg[j-1]);
                        quo_c[l] = {quo_c[l][NDC_CAP-2:0], 1'b1};
                    end else begin
                        rem_c[l] = tr;
                        quo_c[l] = {quo_c[l][NDC_CAP-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[ST_DIV0+j]) begin
                den_reg[j] <= den_reg[j-1];
                vis_reg[j] <= vis_reg[j-1];
                for (int l = 0; l < 2; l++) begin
                    rem_reg[j][l] <= rem_c[l];
                    nlo_reg[j][l] <= nlo_c[l];
                    quo_reg[j][l] <= quo_c[l];
                    neg_reg[j][l] <= neg_reg[j-1][l];
                    ovf_reg[j][l] <= ovf_reg[j-1][l];
                end
            end
        end
    end

    // Scale stage: signed normalized coordinate times the screen size.
    logic [NDC_CAP:0]        mag_c [2];
    logic signed [NW-1:0]    ndc_c [2];
    logic signed [CFG_W:0]   size_c [2];

    always_comb begin
        size_c[0] = $signed({1'b0, width_reg});
        size_c[1] = $signed({1'b0, height_reg});
        for (int l = 0; l < 2; l++) begin
            mag_c[l] = ovf_reg[NDS][l] ? ((NDC_CAP+1)'(1) << NDC_CAP)
                                       : {1'b0, quo_reg[NDS][l]};
            ndc_c[l] = neg_reg[NDS][l] ? -$signed({1'b0, mag_c[l]})
                                       : $signed({1'b0, mag_c[l]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SCALE]) begin
            svis_reg <= vis_reg[NDS];
            for (int l = 0; l < 2; l++) begin
                sprod_reg[l] <= PRW'(ndc_c[l]) * PRW'(size_c[l]);
            end
        end
    end

    // Output stage: center offset, rounding term and saturation.
    logic signed [63:0] sx_c;
    logic signed [63:0] sy_c;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < 64'shFFFF_FFFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb begin
        sx_c = ($signed(64'(width_reg)) <<< (FRAC_BITS - 1)) +
               ((64'(sprod_reg[0]) >>> 1) + HALF);
        sy_c = ($signed(64'(height_reg)) <<< (FRAC_BITS - 1)) -
               ((64'(sprod_reg[1]) >>> 1) + HALF);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            vis_out_reg <= svis_reg;
            sx_out_reg  <= svis_reg ? sat32(sx_c) : '0;
            sy_out_reg  <= svis_reg ? sat32(sy_c) : '0;
        end
    end

    assign m_valid    = vld_reg[ST_OUT];
    assign m_visible  = vis_out_reg;
    assign m_screen_x = sx_out_reg;
    assign m_screen_y = sy_out_reg;

endmodule

@@ rtl/wsp_checker.sv @@
// Port-level checks for the projection block and their bind to the top level.
`timescale 1ns / 1ps

module wsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_visible,
    input logic [31:0] m_screen_x,
    input logic [31:0] m_screen_y
);

    // A result still waiting keeps its value until the transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible) &&
        $stable(m_screen_x) && $stable(m_screen_y))
        else $error("result changed while stalled");

    // A point behind the threshold reports zero coordinates.
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_screen_x == 32'd0 && m_screen_y == 32'd0)
        else $error("hidden point with nonzero coordinates");

    // With the output empty, the pipeline can always take a new item.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) == 1'b0 |-> !m_valid)
        else $error("result present right after reset");

endmodule

bind world_to_screen_projection_top wsp_checker u_wsp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_visible  (m_visible),
    .m_screen_x (m_screen_x),
    .m_screen_y (m_screen_y)
);

@@ tb/tb_world_to_screen_projection_top.sv @@
// Self-checking testbench for the world-to-screen projection block.
`timescale 1ns / 1ps

module tb_world_to_screen_projection_top;
    import wsp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        cmd_t        command;
        logic [3:0]  coef_index;
        logic [31:0] coef_value;
        logic [31:0] world_x;
        logic [31:0] world_y;
        logic [31:0] world_z;
    } point_cmd_t;

    typedef struct packed {
        logic        visible;
        logic [31:0] screen_x;
        logic [31:0] screen_y;
    } pixel_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic s_command;
    logic [3:0] s_coef_index;
    logic signed [31:0] s_coef_value;
    logic signed [31:0] s_world_x;
    logic signed [31:0] s_world_y;
    logic signed [31:0] s_world_z;
    logic m_valid;
    logic m_ready;
    logic m_visible;
    logic signed [31:0] m_screen_x;
    logic signed [31:0] m_screen_y;

    // Predictor state.
    logic signed [63:0] coef_model [NCOEF];
    logic [CFG_W-1:0] width_model;
    logic [CFG_W-1:0] height_model;

    point_cmd_t cmd_queue[$];
    pixel_t pixel_queue[$];
    int errors;
    int gap_left;
    int stall_left;
    bit drive_hold;

    world_to_screen_projection_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_coef_index(s_coef_index), .s_coef_value(s_coef_value),
        .s_world_x(s_world_x), .s_world_y(s_world_y), .s_world_z(s_world_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_visible(m_visible),
        .m_screen_x(m_screen_x), .m_screen_y(m_screen_y)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Row dot product: exact sum of Q.2F products floored to Q.F, plus offset.
    function automatic logic signed [63:0] row_dot(int row, logic signed [63:0] wx,
                                                   logic signed [63:0] wy,
                                                   logic signed [63:0] wz);
        logic signed [127:0] acc;
        acc = coef_model[row*4] * wx + coef_model[row*4+1] * wy
            + coef_model[row*4+2] * wz;
        acc = acc >>> FB;
        return acc[63:0] + coef_model[row*4+3];
    endfunction

    // Normalized coordinate: num * 2^F / den toward zero, capped at 2^46.
    function automatic logic signed [63:0] norm_coord(logic signed [63:0] num,
                                                      logic signed [63:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        q = (mag << FB) / 128'(den);
        if (q > (128'd1 << NDC_CAP)) q = 128'd1 << NDC_CAP;
        if ((mag / 128'(den)) >= (128'd1 << (NDC_CAP - FB))) q = 128'd1 << NDC_CAP;
        return (num < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -128'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Apply one accepted item to the predictor and queue any expected pixel.
    task automatic predict_pixel(point_cmd_t c);
        logic signed [63:0] x, y, d, nx, ny;
        logic signed [127:0] half, sx, sy, w, h;
        pixel_t p;
        if (c.command == CMD_LOAD) begin
            if (c.coef_index < NCOEF)
                coef_model[c.coef_index] = 64'($signed(c.coef_value));
            return;
        end
        x = row_dot(0, $signed(c.world_x), $signed(c.world_y), $signed(c.world_z));
        y = row_dot(1, $signed(c.world_x), $signed(c.world_y), $signed(c.world_z));
        d = row_dot(2, $signed(c.world_x), $signed(c.world_y), $signed(c.world_z));
        p = '0;
        if (d > ((64'sd1 << FB) + 500) / 1000) begin
            nx = norm_coord(x, d);
            ny = norm_coord(y, d);
            half = 128'sd1 <<< (FB - 1);
            w = 128'(width_model);
            h = 128'(height_model);
            sx = w * half + (((128'(nx) * w) >>> 1) + half);
            sy = h * half - (((128'(ny) * h) >>> 1) + half);
            p.visible = 1'b1;
            p.screen_x = clamp32(sx);
            p.screen_y = clamp32(sy);
        end
        pixel_queue.push_back(p);
    endtask

    // Input driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pixel(cmd_queue.pop_front());
            end
            if (s_valid && !s_ready) begin
                // Hold the current transfer.
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_queue.size() > 0 && !drive_hold
                         && !(s_valid && s_ready && cmd_queue.size() == 0)) begin
                s_valid <= 1'b1;
                s_command <= cmd_queue[0].command;
                s_coef_index <= cmd_queue[0].coef_index;
                s_coef_value <= cmd_queue[0].coef_value;
                s_world_x <= cmd_queue[0].world_x;
                s_world_y <= cmd_queue[0].world_y;
                s_world_z <= cmd_queue[0].world_z;
                gap_left <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge aclk) begin
        pixel_t exp_p;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    exp_p = pixel_queue.pop_front();
                    if (m_visible !== exp_p.visible) begin
                        $error("visible: expected %0d, got %0d", exp_p.visible, m_visible);
                        errors++;
                    end
                    if (m_screen_x !== exp_p.screen_x) begin
                        $error("screen_x: expected %0d, got %0d",
                               $signed(exp_p.screen_x), m_screen_x);
                        errors++;
                    end
                    if (m_screen_y !== exp_p.screen_y) begin
                        $error("screen_y: expected %0d, got %0d",
                               $signed(exp_p.screen_y), m_screen_y);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
        endcase
    endfunction

    function automatic point_cmd_t make_load(int idx, logic [31:0] v);
        point_cmd_t c;
        c = '0;
        c.command = CMD_LOAD;
        c.coef_index = 4'(idx);
        c.coef_value = v;
        c.world_x = $urandom();
        c.world_y = $urandom();
        c.world_z = $urandom();
        return c;
    endfunction

    function automatic point_cmd_t make_point(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z);
        point_cmd_t c;
        c.command = CMD_PROJECT;
        c.coef_index = 4'($urandom());
        c.coef_value = $urandom();
        c.world_x = x;
        c.world_y = y;
        c.world_z = z;
        return c;
    endfunction

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || s_valid || pixel_queue.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SCREEN_WIDTH) width_model = v;
        else height_model = v;
    endtask

    // Loads a typical camera: x and y from world x and y, depth from z.
    task automatic load_camera();
        int i;
        for (i = 0; i < NCOEF; i++) begin
            if (i == 0 || i == 5) cmd_queue.push_back(make_load(i, $urandom_range(1, 4) << FB));
            else if (i == 10) cmd_queue.push_back(make_load(i, 1 << FB));
            else if ($urandom_range(0, 3) == 0) cmd_queue.push_back(make_load(i, $urandom()));
            else cmd_queue.push_back(make_load(i,
                     32'($signed($urandom_range(0, 1 << FB)) - (1 << (FB - 1)))));
        end
    endtask

    initial begin
        int i;
        int phase;
        errors = 0;
        drive_hold = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_command = 1'b0;
        s_coef_index = '0;
        s_coef_value = '0;
        s_world_x = '0;
        s_world_y = '0;
        s_world_z = '0;
        width_model = SCREEN_WIDTH_RST;
        height_model = SCREEN_HEIGHT_RST;
        for (i = 0; i < NCOEF; i++) coef_model[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: all-zero store gives depth 0, so the point is not visible.
        cmd_queue.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        // Out-of-range slots are ignored.
        cmd_queue.push_back(make_load(12, 32'hFFFF_FFFF));
        cmd_queue.push_back(make_load(15, 32'h7FFF_FFFF));
        // Identity-like camera; depth equals world z.
        cmd_queue.push_back(make_load(0, 1 << FB));
        cmd_queue.push_back(make_load(5, 1 << FB));
        cmd_queue.push_back(make_load(10, 1 << FB));
        cmd_queue.push_back(make_point(0, 0, 66));              // at the threshold
        cmd_queue.push_back(make_point(0, 0, 67));              // just above
        cmd_queue.push_back(make_point(1 << FB, 1 << FB, 2 << FB));
        cmd_queue.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 67));
        cmd_queue.push_back(make_point(32'h8000_0000, 32'h7FFF_FFFF, 1 << FB));
        cmd_queue.push_back(make_point(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF));
        cmd_queue.push_back(make_point(0, 0, 32'h8000_0000));   // negative depth
        cmd_queue.push_back(make_load(11, 32'h8000_0000));
        cmd_queue.push_back(make_load(3, 32'h7FFF_FFFF));
        cmd_queue.push_back(make_point(0, 0, 32'h7FFF_FFFF));
        cmd_queue.push_back(make_load(11, 0));
        cmd_queue.push_back(make_load(3, 0));
        wait_idle();

        // Phases cycle through screen sizes including the extremes and zero.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_SCREEN_WIDTH, CFG_W'(1));
                    write_reg(REG_SCREEN_HEIGHT, CFG_W'(1));
                end
                1: begin
                    write_reg(REG_SCREEN_WIDTH, CFG_W'(8192));
                    write_reg(REG_SCREEN_HEIGHT, CFG_W'(8192));
                end
                2: begin
                    write_reg(REG_SCREEN_WIDTH, CFG_W'(0));
                    write_reg(REG_SCREEN_HEIGHT, CFG_W'(16383));
                end
                3: begin
                    write_reg(REG_SCREEN_WIDTH, CFG_W'(1920));
                    write_reg(REG_SCREEN_HEIGHT, CFG_W'(1080));
                end
                default: begin
                    write_reg(REG_SCREEN_WIDTH, CFG_W'($urandom_range(1, 8192)));
                    write_reg(REG_SCREEN_HEIGHT, CFG_W'($urandom_range(1, 8192)));
                end
            endcase
            load_camera();
            for (i = 0; i < 125; i++) begin
                if ($urandom_range(0, 9) == 0)
                    cmd_queue.push_back(make_load($urandom_range(0, 15), $urandom()));
                else if ($urandom_range(0, 4) == 0)
                    cmd_queue.push_back(make_point($urandom(), $urandom(), $urandom()));
                else
                    cmd_queue.push_back(make_point(rand_coord(), rand_coord(),
                        $urandom_range(0, 3) == 0 ? rand_coord()
                                                  : 32'($urandom_range(0, 100 << FB))));
                // Sender pause: hold off until every result has come back.
                if (phase == 4 && i == 60) begin
                    drive_hold = 1'b1;
                    while (cmd_queue.size() > 1 || s_valid || pixel_queue.size() > 0)
                        begin drive_hold = 1'b0; @(posedge aclk); end
                    drive_hold = 1'b1;
                    while (pixel_queue.size() > 0) @(posedge aclk);
                    drive_hold = 1'b0;
                end
            end
            wait_idle();
        end

        if (errors == 0 && pixel_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
